// File: design/epoch_seconds_to_calendar_date_assert.svh
// Assertion macros for the epoch seconds to calendar date block.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ESD_ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ESD_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ESD_ASSERT_IMPL(label, ck, rn, ante, cons)
`define ESD_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// File: design/esd_pkg.sv
package esd_pkg;

  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [11:0] BASE_YEAR      = 12'd1970;
  localparam logic [8:0]  YEAR_DAYS      = 9'd365;
  localparam logic [8:0]  LEAP_YEAR_DAYS = 9'd366;
  localparam logic [3:0]  MONTH_LAST     = 4'd11;
  localparam logic [3:0]  DIV_STEPS_LAST = 4'd15;

  // Year residues of the base year: mod 4, mod 100, mod 400.
  localparam logic [1:0] C4_INIT   = 2'd2;
  localparam logic [6:0] C100_INIT = 7'd70;
  localparam logic [8:0] C400_INIT = 9'd370;
  localparam logic [6:0] C100_LAST = 7'd99;
  localparam logic [8:0] C400_LAST = 9'd399;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_YEAR  = 5'b00100,
    S_MONTH = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    OP_DIV   = 2'd0,
    OP_YEAR  = 2'd1,
    OP_MONTH = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       leap;
    logic [3:0] month;
    logic       shift_bit;
  } alu_ctl_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mo);
    logic [4:0] len;
    case (mo)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: design/esd_alu.sv
module esd_alu (
  input  esd_pkg::alu_ctl_t ctl,
  input  logic [16:0]       acc,
  output logic [16:0]       res,
  output logic              ge
);
  import esd_pkg::*;

  logic [17:0] opa;
  logic [17:0] opb;
  logic [17:0] diff;

  // Pick the subtrahend for the step in progress.
  always_comb begin
    opa = {1'b0, acc};
    opb = '0;
    unique case (ctl.op)
      OP_DIV: begin
        opa = {acc, ctl.shift_bit};
        opb = {1'b0, SECS_PER_DAY};
      end
      OP_YEAR: begin
        opb = {9'd0, (ctl.leap ? LEAP_YEAR_DAYS : YEAR_DAYS)};
      end
      OP_MONTH: begin
        opb = {13'd0, month_len(ctl.leap, ctl.month)};
      end
      default: begin
        opb = '0;
      end
    endcase
  end

  assign diff = opa - opb;
  assign ge   = (opa >= opb);
  // Keep the difference when it fits, otherwise pass the operand through.
  assign res  = ge ? diff[16:0] : opa[16:0];

endmodule

// File: design/epoch_seconds_to_calendar_date.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_epoch_seconds[31:0]
// out      output     out_valid/out_stall out_day_of_month[4:0], out_month_number[3:0],
//                                         out_year_number[11:0]
//
// An item runs from acceptance to result in these steps: 16 steps of the shared
// subtractor for the division by 86400, one step per elapsed year plus one that ends
// the walk (up to 137), one step per elapsed month plus one that ends it (up to 12),
// and a final step that loads the output register. Late December 2105 is the slowest input.
// The next item is accepted from the cycle after the result loads.
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops out_valid.
// A stalled result holds in the output register; a new item is accepted meanwhile
// and waits at its last step until the output register frees up.
`include "epoch_seconds_to_calendar_date_assert.svh"

module epoch_seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_number,
  output logic [11:0] out_year_number
);
  import esd_pkg::*;

  state_t      st_r, st_nxt;
  logic [16:0] acc_r, acc_nxt;       // division remainder, then days left
  logic [15:0] shf_r, shf_nxt;       // dividend low bits, then quotient
  logic [3:0]  cnt_r, cnt_nxt;       // division step count
  logic [11:0] yr_r, yr_nxt;
  logic [3:0]  mo_r, mo_nxt;
  logic [1:0]  c4_r, c4_nxt;
  logic [6:0]  c100_r, c100_nxt;
  logic [8:0]  c400_r, c400_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [11:0] oyr_r, oyr_nxt;

  alu_ctl_t    ctl;
  logic [16:0] alu_res;
  logic        alu_ge;
  logic        leap;
  logic        in_acc;
  logic        walking;
  logic        date_ok;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE);

  // Leap rule from the running residues of the year.
  assign leap = ((c4_r == 2'd0) && (c100_r != 7'd0)) || (c400_r == 9'd0);

  always_comb begin
    ctl.op        = OP_DIV;
    ctl.leap      = leap;
    ctl.month     = mo_r;
    ctl.shift_bit = shf_r[15];
    unique case (st_r)
      S_YEAR:  ctl.op = OP_YEAR;
      S_MONTH: ctl.op = OP_MONTH;
      default: ctl.op = OP_DIV;
    endcase
  end

  esd_alu u_alu (
    .ctl (ctl),
    .acc (acc_r),
    .res (alu_res),
    .ge  (alu_ge)
  );

  always_comb begin
    st_nxt        = st_r;
    acc_nxt       = acc_r;
    shf_nxt       = shf_r;
    cnt_nxt       = cnt_r;
    yr_nxt        = yr_r;
    mo_nxt        = mo_r;
    c4_nxt        = c4_r;
    c100_nxt      = c100_r;
    c400_nxt      = c400_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    oyr_nxt       = oyr_r;
    // Drop the result once it is taken.
    out_valid_nxt = out_valid_r && out_stall;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          // High half is below 86400 already, so start the division at bit 15.
          acc_nxt  = {1'b0, in_epoch_seconds[31:16]};
          shf_nxt  = in_epoch_seconds[15:0];
          cnt_nxt  = '0;
          yr_nxt   = BASE_YEAR;
          c4_nxt   = C4_INIT;
          c100_nxt = C100_INIT;
          c400_nxt = C400_INIT;
          mo_nxt   = '0;
          st_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        acc_nxt = alu_res;
        shf_nxt = {shf_r[14:0], alu_ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == DIV_STEPS_LAST) begin
          // Drop the remainder and carry the quotient, the whole days, into the walk.
          acc_nxt = {1'b0, shf_r[14:0], alu_ge};
          st_nxt  = S_YEAR;
        end
      end
      S_YEAR: begin
        acc_nxt = alu_res;
        if (alu_ge) begin
          yr_nxt   = yr_r + 12'd1;
          c4_nxt   = c4_r + 2'd1;
          c100_nxt = (c100_r == C100_LAST) ? 7'd0 : c100_r + 7'd1;
          c400_nxt = (c400_r == C400_LAST) ? 9'd0 : c400_r + 9'd1;
        end else begin
          st_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (alu_ge && (mo_r != MONTH_LAST)) begin
          acc_nxt = alu_res;
          mo_nxt  = mo_r + 4'd1;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          day_nxt       = acc_r[4:0] + 5'd1;
          mon_nxt       = mo_r + 4'd1;
          oyr_nxt       = yr_r;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    shf_r  <= shf_nxt;
    cnt_r  <= cnt_nxt;
    yr_r   <= yr_nxt;
    mo_r   <= mo_nxt;
    c4_r   <= c4_nxt;
    c100_r <= c100_nxt;
    c400_r <= c400_nxt;
    day_r  <= day_nxt;
    mon_r  <= mon_nxt;
    oyr_r  <= oyr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_day_of_month = day_r;
  assign out_month_number = mon_r;
  assign out_year_number  = oyr_r;

  assign walking = (st_r == S_YEAR) || (st_r == S_MONTH);
  assign date_ok = (out_month_number >= 4'd1) && (out_month_number <= 4'd12) &&
                   (out_day_of_month != 5'd0);

  // The mod-4 residue must track the low bits of the mod-400 residue.
  `ESD_ASSERT_IMPL(a_residue_sync, clk, rst_n, walking, (c400_r[1:0] == c4_r))
  // The month walk never passes December.
  `ESD_ASSERT_IMPL(a_month_bound, clk, rst_n, (st_r == S_MONTH), (mo_r <= MONTH_LAST))
  // A fresh result carries a legal month and day.
  `ESD_ASSERT_IMPL(a_result_range, clk, rst_n, $rose(out_valid), date_ok)
  // An accepted item always starts the division.
  `ESD_ASSERT_NEXT(a_accept_div, clk, rst_n, in_acc, (st_r == S_DIV && cnt_r == 4'd0))

endmodule
